FILE: hdl/pid_controller_with_options_defines.svh
// Assertion macros for the PID controller.
`ifndef PID_CONTROLLER_WITH_OPTIONS_DEFINES_SVH
`define PID_CONTROLLER_WITH_OPTIONS_DEFINES_SVH
`ifndef SYNTHESIS
`define PIDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PIDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define PIDC_ASSERT(lbl, clk, rstn, prop, msg)
`define PIDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hdl/pidc_pkg.sv
// Types, constants and helpers for the PID controller.
`default_nettype none
package pidc_pkg;

  localparam int unsigned DW  = 32;
  localparam int unsigned GW  = 31;
  localparam int unsigned DTW = 16;
  localparam int unsigned PW  = 66;
  localparam int unsigned NW  = 57;
  localparam int unsigned VW  = 24;
  localparam int unsigned CIW = 4;
  localparam int unsigned SCW = 10;
  localparam int unsigned OPW = 7;

  localparam logic [16:0]    DERIV_FILTER_RC  = 17'd655;
  localparam logic [16:0]    OUTPUT_FILTER_RC = 17'd655;
  localparam logic [SCW-1:0] STALL_LIMIT      = 10'd500;
  localparam logic [SCW-1:0] STALL_MAX        = 10'd1023;

  localparam int unsigned OPT_BLOCK  = 0;
  localparam int unsigned OPT_TRAP   = 1;
  localparam int unsigned OPT_VRATE  = 2;
  localparam int unsigned OPT_DMEAS  = 3;
  localparam int unsigned OPT_DFILT  = 4;
  localparam int unsigned OPT_ILIMIT = 5;
  localparam int unsigned OPT_OFILT  = 6;

  typedef enum logic [CIW-1:0] {
    CFG_GAIN_P         = 4'd0,
    CFG_GAIN_I         = 4'd1,
    CFG_GAIN_D         = 4'd2,
    CFG_DEAD_ZONE      = 4'd3,
    CFG_OUTPUT_BOUND   = 4'd4,
    CFG_INTEGRAL_BOUND = 4'd5,
    CFG_OPTION_FLAGS   = 4'd6,
    CFG_RATE_WINDOW    = 4'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_MP, ST_MI, ST_MIT, ST_MD, ST_DD, ST_DDW,
    ST_VR, ST_VRD, ST_VRW, ST_DF1, ST_DF2, ST_DF3, ST_DFW,
    ST_INT, ST_SUM, ST_OF1, ST_OF2, ST_OF3, ST_OFW, ST_CLAMP, ST_DONE
  } pidc_state_e;

  typedef struct packed {
    logic signed [DW-1:0] setpoint;
    logic signed [DW-1:0] measurement;
    logic [DTW-1:0]       delta_t;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 blocked;
  } out_item_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] x);
    logic [PW-DW:0] top;
    top = x[PW-1:DW-1];
    if (top == '0 || top == '1) begin
      return x[DW-1:0];
    end else if (x[PW-1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/pidc_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module pidc_div import pidc_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire  [NW-1:0]       dividend_i,
  input  wire  [VW-1:0]       divisor_i,
  output logic                done_o,
  output logic signed [NW-1:0] quotient_o
);

  localparam int unsigned MW = NW - 1;
  localparam int unsigned CW = $clog2(MW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [MW-1:0] mag_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic          neg_q;
  logic [VW:0]   trial;
  logic          qbit;
  logic [NW-1:0] abs_in;

  assign abs_in = dividend_i[NW-1] ? NW'(-dividend_i) : dividend_i;
  assign trial  = {rem_q, mag_q[MW-1]};
  assign qbit   = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= abs_in[MW-1:0];
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[NW-1];
    end else if (busy_q) begin
      rem_q <= qbit ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
      mag_q <= {mag_q[MW-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule
`default_nettype wire

FILE: hdl/pid_controller_with_options.sv
// Top level of the positional PID controller with options.
`default_nettype none
`include "pid_controller_with_options_defines.svh"
// Positional PID in Q16.16 with one shared 33x33 multiplier and one shared
// 56-step divider under a sequencer; one transaction is worked at a time and
// in_stall_o stays high until its result is loaded into the output register.
// An item inside the dead band goes from the check straight to done. Otherwise
// the sequencer runs the multiplies and the derivative divide, plus a
// divide when the variable rate scales the integral step and one each for the
// derivative and output filters; each divide waits on the divider's done. A stalled
// output holds the sequencer in done. A new item may enter while the last result waits.
module pid_controller_with_options import pidc_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output out_item_t      out_data_o,
  input  wire            cfg_we_i,
  input  wire [CIW-1:0]  cfg_idx_i,
  input  wire [DW-1:0]   cfg_data_i
);

  pidc_state_e state_q, state_d;

  logic [GW-1:0]  gain_p_q, gain_i_q, gain_d_q, dead_zone_q, ob_q, ib_q;
  logic [OPW-1:0] opt_q;
  logic [DW-1:0]  rate_q;

  logic signed [DW-1:0] sp_q, ms_q, e_q, ie_q, p_q, it_q, d_q, drive_q;
  logic [DTW-1:0]       dt_q;
  logic [DW-1:0]        ae_q;
  logic                 ss_q;
  logic signed [PW-1:0] prod_q, acc_q;

  logic signed [DW-1:0] isum_q, prev_err_q, prev_meas_q, prev_out_q, prev_der_q;
  logic [SCW-1:0]       stall_cnt_q;
  logic                 stall_flag_q;

  logic      out_valid_q;
  out_item_t out_q;

  // shared units
  logic signed [32:0]   mul_a, mul_b;
  logic signed [PW-1:0] prod_d;
  logic                 div_start, div_done;
  logic [NW-1:0]        div_num;
  logic [VW-1:0]        div_den;
  logic signed [NW-1:0] div_q;

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  pidc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // front-end checks
  logic [DTW-1:0]       dt_in;
  logic signed [32:0]   diff_in, po_x, sp_x;
  logic signed [DW-1:0] e_in;
  logic [DW-1:0]        ae_in, abs_po, abs_sp;
  logic [32:0]          abs_diff;
  logic                 bd_armed, bd_over;
  logic [SCW-1:0]       cnt_new;
  logic                 dead_in, ss_in;
  logic signed [DW-1:0] ie_in;
  logic signed [32:0]   trap_sum;

  assign dt_in    = (in_data_i.delta_t == '0) ? DTW'(1) : in_data_i.delta_t;
  assign diff_in  = 33'(sp_q) - 33'(ms_q);
  assign e_in     = sat32(PW'(diff_in));
  assign ae_in    = e_in[DW-1] ? DW'(-33'(e_in)) : DW'(e_in);
  assign po_x     = 33'(prev_out_q);
  assign abs_po   = po_x[32] ? DW'(-po_x) : DW'(po_x);
  assign sp_x     = 33'(sp_q);
  assign abs_sp   = sp_x[32] ? DW'(-sp_x) : DW'(sp_x);
  assign abs_diff = diff_in[32] ? 33'(-34'(diff_in)) : 33'(diff_in);
  assign bd_armed = !((42'(abs_po) * 42'd1000 < 42'(ob_q)) || (abs_sp <= DW'(6)));
  assign bd_over  = (39'(abs_diff) * 39'd20) > (39'(abs_sp) * 39'd19);
  assign cnt_new  = bd_over ? ((stall_cnt_q == STALL_MAX) ? stall_cnt_q
                                                          : stall_cnt_q + 1'b1) : '0;
  assign dead_in  = (ae_in <= DW'(dead_zone_q));
  assign ss_in    = (e_in > 0 && isum_q > 0) || (e_in < 0 && isum_q < 0);
  assign trap_sum = 33'(e_in) + 33'(prev_err_q);
  assign ie_in    = opt_q[OPT_TRAP] ? DW'(trap_sum >>> 1) : e_in;

  // stage values
  logic signed [DW-1:0] sh_sat;
  logic signed [32:0]   dsrc;
  logic signed [DW-1:0] dsat;
  logic [VW-1:0]        coef_a, coef_b;
  logic [32:0]          win_hi;
  logic                 vr_on, vr_in;
  logic [32:0]          vr_fac;

  assign sh_sat = sat32(prod_q >>> 16);
  assign dsrc   = opt_q[OPT_DMEAS] ? (33'(prev_meas_q) - 33'(ms_q))
                                   : (33'(e_q) - 33'(prev_err_q));
  assign dsat   = sat32(PW'(dsrc));
  assign coef_b = {rate_q[15:0], 8'd0};
  assign coef_a = {rate_q[31:16], 8'd0};
  assign win_hi = 33'(coef_a) + 33'(coef_b);
  assign vr_on  = opt_q[OPT_VRATE] && ss_q && (ae_q > DW'(coef_b));
  assign vr_in  = (33'(ae_q) <= win_hi);
  assign vr_fac = win_hi - 33'(ae_q);

  // integration with anti-windup
  logic signed [33:0]   ti, to, abs_to, ib_s, isum_base, it_eff;
  logic signed [DW-1:0] isum_new, drive_sum;
  logic signed [32:0]   ob_s;

  assign ob_s = $signed({2'b00, ob_q});
  assign ib_s = $signed({3'b000, ib_q});
  assign ti   = 34'(isum_q) + 34'(it_q);
  assign to   = 34'(p_q) + 34'(isum_q) + 34'(d_q);
  assign abs_to = to[33] ? -to : to;

  always_comb begin
    isum_base = 34'(isum_q);
    it_eff    = 34'(it_q);
    if (opt_q[OPT_ILIMIT]) begin
      if (abs_to > 34'(ob_s) && ss_q) begin
        it_eff = '0;
      end
      if (ti > ib_s) begin
        it_eff    = '0;
        isum_base = ib_s;
      end
      if (ti < -ib_s) begin
        it_eff    = '0;
        isum_base = -ib_s;
      end
    end
  end

  assign isum_new  = sat32(PW'(isum_base + it_eff));
  assign drive_sum = sat32(PW'(34'(p_q) + 34'(isum_q) + 34'(d_q)));

  logic out_free, out_load, drive_in_bound;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_DONE) && out_free;
  assign drive_in_bound = (33'(drive_q) <= ob_s) && (33'(drive_q) >= -ob_s);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: state_d = dead_in ? ST_DONE : ST_MP;
      ST_MP:    state_d = ST_MI;
      ST_MI:    state_d = ST_MIT;
      ST_MIT:   state_d = ST_MD;
      ST_MD:    state_d = ST_DD;
      ST_DD:    state_d = ST_DDW;
      ST_DDW:   if (div_done) state_d = ST_VR;
      ST_VR:    state_d = (vr_on && vr_in) ? ST_VRD : ST_DF1;
      ST_VRD:   state_d = ST_VRW;
      ST_VRW:   if (div_done) state_d = ST_DF1;
      ST_DF1:   state_d = opt_q[OPT_DFILT] ? ST_DF2 : ST_INT;
      ST_DF2:   state_d = ST_DF3;
      ST_DF3:   state_d = ST_DFW;
      ST_DFW:   if (div_done) state_d = ST_INT;
      ST_INT:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_OF1;
      ST_OF1:   state_d = opt_q[OPT_OFILT] ? ST_OF2 : ST_CLAMP;
      ST_OF2:   state_d = ST_OF3;
      ST_OF3:   state_d = ST_OFW;
      ST_OFW:   if (div_done) state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    unique case (state_q)
      ST_MP: begin
        mul_a = $signed({2'b00, gain_p_q});
        mul_b = 33'(e_q);
      end
      ST_MI: begin
        mul_a = $signed({2'b00, gain_i_q});
        mul_b = 33'(ie_q);
      end
      ST_MIT: begin
        mul_a = 33'(sh_sat);
        mul_b = $signed({17'd0, dt_q});
      end
      ST_MD: begin
        mul_a = $signed({2'b00, gain_d_q});
        mul_b = 33'(dsat);
      end
      ST_DD: begin
        div_start = 1'b1;
        div_num   = NW'(sh_sat) <<< 16;
        div_den   = VW'(dt_q);
      end
      ST_VR: begin
        mul_a = 33'(it_q);
        mul_b = $signed(vr_fac);
      end
      ST_VRD: begin
        div_start = 1'b1;
        div_num   = prod_q[NW-1:0];
        div_den   = coef_a;
      end
      ST_DF1: begin
        mul_a = 33'(d_q);
        mul_b = $signed({17'd0, dt_q});
      end
      ST_DF2: begin
        mul_a = 33'(prev_der_q);
        mul_b = $signed(33'(DERIV_FILTER_RC));
      end
      ST_DF3: begin
        div_start = 1'b1;
        div_num   = NW'(acc_q + prod_q);
        div_den   = VW'(DERIV_FILTER_RC) + VW'(dt_q);
      end
      ST_OF1: begin
        mul_a = 33'(drive_q);
        mul_b = $signed({17'd0, dt_q});
      end
      ST_OF2: begin
        mul_a = 33'(prev_out_q);
        mul_b = $signed(33'(OUTPUT_FILTER_RC));
      end
      ST_OF3: begin
        div_start = 1'b1;
        div_num   = NW'(acc_q + prod_q);
        div_den   = VW'(OUTPUT_FILTER_RC) + VW'(dt_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      dead_zone_q  <= '0;
      ob_q         <= '1;
      ib_q         <= '1;
      opt_q        <= '0;
      rate_q       <= '0;
      isum_q       <= '0;
      prev_err_q   <= '0;
      prev_meas_q  <= '0;
      prev_out_q   <= '0;
      prev_der_q   <= '0;
      stall_cnt_q  <= '0;
      stall_flag_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_GAIN_P:         gain_p_q    <= cfg_data_i[GW-1:0];
          CFG_GAIN_I:         gain_i_q    <= cfg_data_i[GW-1:0];
          CFG_GAIN_D:         gain_d_q    <= cfg_data_i[GW-1:0];
          CFG_DEAD_ZONE:      dead_zone_q <= cfg_data_i[GW-1:0];
          CFG_OUTPUT_BOUND:   ob_q        <= cfg_data_i[GW-1:0];
          CFG_INTEGRAL_BOUND: ib_q        <= cfg_data_i[GW-1:0];
          CFG_OPTION_FLAGS:   opt_q       <= cfg_data_i[OPW-1:0];
          CFG_RATE_WINDOW:    rate_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_CHECK && opt_q[OPT_BLOCK] && bd_armed) begin
        stall_cnt_q <= cnt_new;
        if (cnt_new > STALL_LIMIT) stall_flag_q <= 1'b1;
      end
      if (state_q == ST_INT) isum_q <= isum_new;
      if (state_q == ST_CLAMP) prev_der_q <= d_q;
      if (out_load) begin
        prev_meas_q <= ms_q;
        prev_err_q  <= e_q;
        prev_out_q  <= drive_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (out_load) begin
      out_q.drive   <= drive_q;
      out_q.blocked <= stall_flag_q;
    end
    case (state_q)
      ST_IDLE: begin
        sp_q <= in_data_i.setpoint;
        ms_q <= in_data_i.measurement;
        dt_q <= dt_in;
      end
      ST_CHECK: begin
        e_q     <= e_in;
        ae_q    <= ae_in;
        ss_q    <= ss_in;
        ie_q    <= ie_in;
        drive_q <= '0;
      end
      ST_MI:    p_q  <= sh_sat;
      ST_MD:    it_q <= DW'(prod_q >>> 16);
      ST_DDW:   if (div_done) d_q <= sat32(PW'(div_q));
      ST_VR:    if (vr_on && !vr_in) it_q <= '0;
      ST_VRW:   if (div_done) it_q <= div_q[DW-1:0];
      ST_DF2:   acc_q <= prod_q;
      ST_DFW:   if (div_done) d_q <= div_q[DW-1:0];
      ST_SUM:   drive_q <= drive_sum;
      ST_OF2:   acc_q <= prod_q;
      ST_OFW:   if (div_done) drive_q <= div_q[DW-1:0];
      ST_CLAMP: begin
        if (33'(drive_q) > ob_s) begin
          drive_q <= DW'(ob_s);
        end else if (33'(drive_q) < -ob_s) begin
          drive_q <= DW'(-ob_s);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PIDC_ASSERT(a_drive_bound, clk_i, rst_ni, out_load |-> drive_in_bound, "drive beyond bound")
  `PIDC_ASSERT_NEXT(a_flag_sticky, clk_i, rst_ni, stall_flag_q, stall_flag_q, "blocked flag lost")
  `PIDC_ASSERT_NEXT(a_one_txn, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "second transaction taken")

endmodule
`default_nettype wire
